### rtl/core/binary_to_decimal_ascii_defines.svh
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_defines
// Assertion macros used by the converter checker file.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// same-cycle implication, held off during reset
`define B2DA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define B2DA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg
// Types and constants of the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package b2da_pkg;

    localparam int MAX_DIGITS_DEF = 16;
    localparam int VALUE_BITS_DEF = 32;
    localparam int BITS_PER_STAGE = 8;
    localparam int COUNT_W        = 5;
    localparam int DIGIT_W        = 6;
    localparam logic [3:0] DD_THRESH = 4'd5;
    localparam logic [3:0] DD_ADJUST = 4'd3;
    localparam logic [DIGIT_W-1:0] ASCII_ZERO = 6'h30;

    typedef struct packed {
        logic               vld;
        logic [COUNT_W-1:0] cnt;
    } t_ctl;

endpackage

`default_nettype wire

### rtl/core/b2da_dd_stage.sv
// ----------------------------------------------------------------------------
// b2da_dd_stage
// One pipeline stage of shift-and-add-3 conversion, a byte of bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_dd_stage #(
    parameter int BCD_DIGITS = 10,
    parameter int VAL_W      = 32
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_adv,
    input  wire b2da_pkg::t_ctl          i_ctl,
    input  wire logic [BCD_DIGITS*4-1:0] i_bcd,
    input  wire logic [VAL_W-1:0]        i_val,
    output b2da_pkg::t_ctl               o_ctl,
    output logic [BCD_DIGITS*4-1:0]      o_bcd,
    output logic [VAL_W-1:0]             o_val
);
    import b2da_pkg::*;

    logic                    r_vld;
    logic [COUNT_W-1:0]      r_cnt;
    logic [BCD_DIGITS*4-1:0] r_bcd;
    logic [VAL_W-1:0]        r_val;
    logic [BCD_DIGITS*4-1:0] n_bcd;
    logic [VAL_W-1:0]        n_val;

    always_comb begin
        n_bcd = i_bcd;
        n_val = i_val;
        for (int b = 0; b < BITS_PER_STAGE; b++) begin
            for (int d = 0; d < BCD_DIGITS; d++) begin
                if (n_bcd[d*4 +: 4] >= DD_THRESH) begin
                    n_bcd[d*4 +: 4] = n_bcd[d*4 +: 4] + DD_ADJUST;
                end
            end
            n_bcd = {n_bcd[BCD_DIGITS*4-2:0], n_val[VAL_W-1]};
            n_val = {n_val[VAL_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_cnt <= i_ctl.cnt;
            r_bcd <= n_bcd;
            r_val <= n_val;
        end
    end

    assign o_ctl.vld = r_vld;
    assign o_ctl.cnt = r_cnt;
    assign o_bcd     = r_bcd;
    assign o_val     = r_val;

endmodule

`default_nettype wire

### rtl/core/b2da_emit.sv
// ----------------------------------------------------------------------------
// b2da_emit
// Digit sequencer: sends the requested digits, most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_emit #(
    parameter int BCD_DIGITS = 10,
    parameter int MAX_DIGITS = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_stall,
    input  wire b2da_pkg::t_ctl          i_ctl,
    input  wire logic [BCD_DIGITS*4-1:0] i_bcd,
    output logic                         o_adv,
    output logic                         o_valid,
    output logic [b2da_pkg::DIGIT_W-1:0] o_ascii_digit,
    output logic                         o_last_digit
);
    import b2da_pkg::*;

    localparam int PW = $clog2(MAX_DIGITS + 1);

    logic                    r_busy;
    logic [PW-1:0]           r_pos;
    logic [BCD_DIGITS*4-1:0] r_bcd;
    logic [COUNT_W-1:0]      cnt_sat;
    logic                    at_last;
    logic                    load_ok;
    logic                    load;
    logic [3:0]              digit;

    assign cnt_sat = (i_ctl.cnt > COUNT_W'(MAX_DIGITS)) ? COUNT_W'(MAX_DIGITS) : i_ctl.cnt;
    assign at_last = (r_pos == '0);
    assign load_ok = !r_busy || (!i_stall && at_last);
    assign load    = i_ctl.vld && load_ok && (cnt_sat != '0);
    assign o_adv   = !i_ctl.vld || load_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (load) begin
            r_busy <= 1'b1;
        end else if (r_busy && !i_stall && at_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pos <= PW'(cnt_sat - COUNT_W'(1));
            r_bcd <= i_bcd;
        end else if (r_busy && !i_stall) begin
            r_pos <= r_pos - PW'(1);
        end
    end

    // positions above the converted width read as zero
    always_comb begin
        digit = '0;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (32'(r_pos) == i) begin
                digit = r_bcd[i*4 +: 4];
            end
        end
    end

    assign o_valid       = r_busy;
    assign o_ascii_digit = ASCII_ZERO | {2'b00, digit};
    assign o_last_digit  = at_last;

endmodule

`default_nettype wire

### rtl/core/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Unsigned binary to ASCII decimal digits, most significant digit first.
//
// Input channel i_valid/o_stall carries i_value and i_digit_count. Output
// channel o_valid/i_stall carries one digit per item, o_last_digit on the
// least significant one. A count of zero gives no digits; a count above
// MAX_DIGITS is treated as MAX_DIGITS; positions beyond the value give '0'.
// Conversion is a pipeline of ceil(VALUE_BITS/8) shift-and-add-3 stages
// (4 at 32 bits), one input bit each step, eight steps per stage.
// An accepted item passes through every stage register before the sequencer
// loads it. The digit sequencer sends one digit per cycle when the receiver
// does not stall, and loads the next item as it sends the current last digit.
// Receiver stall holds the current digit and backs up the pipeline
// into o_stall. Synchronous reset empties all stages and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii #(
    parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF,
    parameter int VALUE_BITS = b2da_pkg::VALUE_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [VALUE_BITS-1:0]   i_value,
    input  wire logic [b2da_pkg::COUNT_W-1:0] i_digit_count,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [b2da_pkg::DIGIT_W-1:0] o_ascii_digit,
    output logic                         o_last_digit
);
    import b2da_pkg::*;

    localparam int NSTG       = (VALUE_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    localparam int VAL_W      = NSTG * BITS_PER_STAGE;
    localparam int BCD_DIGITS = (VALUE_BITS * 3) / 10 + 1;

    t_ctl                    ctl [NSTG+1];
    logic [BCD_DIGITS*4-1:0] bcd [NSTG+1];
    logic [VAL_W-1:0]        val [NSTG+1];
    logic                    adv;

    assign ctl[0].vld = i_valid;
    assign ctl[0].cnt = i_digit_count;
    assign bcd[0]     = '0;
    assign val[0]     = VAL_W'(i_value);
    assign o_stall    = !adv;

    for (genvar s = 0; s < NSTG; s++) begin : g_stage
        b2da_dd_stage #(
            .BCD_DIGITS (BCD_DIGITS),
            .VAL_W      (VAL_W)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_ctl   (ctl[s]),
            .i_bcd   (bcd[s]),
            .i_val   (val[s]),
            .o_ctl   (ctl[s+1]),
            .o_bcd   (bcd[s+1]),
            .o_val   (val[s+1])
        );
    end

    b2da_emit #(
        .BCD_DIGITS (BCD_DIGITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_stall       (i_stall),
        .i_ctl         (ctl[NSTG]),
        .i_bcd         (bcd[NSTG]),
        .o_adv         (adv),
        .o_valid       (o_valid),
        .o_ascii_digit (o_ascii_digit),
        .o_last_digit  (o_last_digit)
    );

endmodule

`default_nettype wire

### rtl/core/b2da_checker.sv
// ----------------------------------------------------------------------------
// b2da_checker
// Port-level checks of the converter output channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_to_decimal_ascii_defines.svh"

module b2da_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_stall,
    input wire logic                         o_valid,
    input wire logic [b2da_pkg::DIGIT_W-1:0] o_ascii_digit,
    input wire logic                         o_last_digit
);
    import b2da_pkg::*;

    `B2DA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid, "item dropped under stall")
    `B2DA_ASSERT_NOW(a_range, i_clk, i_rst_n, o_valid, (o_ascii_digit >= ASCII_ZERO) && (o_ascii_digit <= (ASCII_ZERO + 6'd9)), "digit out of range")
    `B2DA_ASSERT_NEXT(a_run, i_clk, i_rst_n, o_valid && !i_stall && !o_last_digit, o_valid, "digit run broken")

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (.*);

`default_nettype wire

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for binary_to_decimal_ascii: sends values with digit counts,
// predicts the zero-padded decimal digit items and checks each one in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb;
    import b2da_pkg::*;

    localparam int MAX_D = MAX_DIGITS_DEF;
    localparam int VBITS = VALUE_BITS_DEF;

    typedef struct packed {
        logic [DIGIT_W-1:0] ascii;
        logic               last;
    } t_digit;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic [VBITS-1:0]     i_value = '0;
    logic [COUNT_W-1:0]   i_digit_count = '0;
    logic                 i_stall = 1'b0;
    wire logic            o_stall;
    wire logic            o_valid;
    wire logic [DIGIT_W-1:0] o_ascii_digit;
    wire logic            o_last_digit;

    t_digit digits_due[$];
    int     n_err = 0;
    int     stall_mode = 0;

    binary_to_decimal_ascii u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_value       (i_value),
        .i_digit_count (i_digit_count),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_ascii_digit (o_ascii_digit),
        .o_last_digit  (o_last_digit)
    );

    always #5 i_clk = ~i_clk;

    function automatic void predict_digits(logic [VBITS-1:0] val, logic [COUNT_W-1:0] cnt);
        logic [63:0] rest;
        logic [3:0]  dig [MAX_D];
        int          n;
        t_digit      d;
        rest = 64'(val);
        n = (cnt > MAX_D) ? MAX_D : int'(cnt);
        for (int p = 0; p < MAX_D; p++) begin
            dig[p] = 4'(rest % 10);
            rest = rest / 10;
        end
        for (int k = n - 1; k >= 0; k--) begin
            d.ascii = ASCII_ZERO + DIGIT_W'(dig[k]);
            d.last  = (k == 0);
            digits_due.push_back(d);
        end
    endfunction

    // receiver stall pattern
    always @(posedge i_clk) begin
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            default: i_stall <= ($urandom_range(0, 1) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_digit d;
        if (i_rst_n && o_valid && !i_stall) begin
            if (digits_due.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected digit %h last %b", o_ascii_digit, o_last_digit);
            end else begin
                d = digits_due.pop_front();
                if (d.ascii !== o_ascii_digit || d.last !== o_last_digit) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("digit mismatch: exp %h/%b got %h/%b",
                                 d.ascii, d.last, o_ascii_digit, o_last_digit);
                end
            end
        end
    end

    task automatic send_item(logic [VBITS-1:0] val, logic [COUNT_W-1:0] cnt);
        i_valid       <= 1'b1;
        i_value       <= val;
        i_digit_count <= cnt;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_digits(val, cnt);
    endtask

    task automatic idle_gap();
        int g;
        g = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic test_directed();
        logic [VBITS-1:0] vals [6] = '{32'd0, 32'hFFFF_FFFF, 32'd1234567890,
                                      32'd9, 32'd1_000_000_000, 32'hAAAA_5555};
        foreach (vals[i]) send_item(vals[i], COUNT_W'(10));
        send_item(32'd42, 5'd0);
        send_item(32'hFFFF_FFFF, 5'd16);
        send_item(32'hFFFF_FFFF, 5'd31);
        send_item(32'd123456, 5'd17);
        send_item(32'd987654321, 5'd3);
        send_item(32'd7, 5'd1);
        send_item(32'h5555_AAAA, 5'd12);
        i_valid <= 1'b0;
    endtask

    task automatic test_random();
        logic [VBITS-1:0]   v;
        logic [COUNT_W-1:0] c;
        for (int i = 0; i < 250; i++) begin
            if (i % 60 == 0) stall_mode = $urandom_range(0, 2);
            case ($urandom_range(0, 3))
                0: v = $urandom_range(0, 999);
                1: v = {$urandom} >> $urandom_range(0, 31);
                default: v = $urandom;
            endcase
            c = ($urandom_range(0, 9) == 0) ? COUNT_W'($urandom_range(17, 31))
                                           : COUNT_W'($urandom_range(0, 16));
            send_item(v, c);
            if (i % ($urandom_range(1, 8)) == 0) idle_gap();
        end
        i_valid <= 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        while (digits_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (n_err == 0 && digits_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end
endmodule

`default_nettype wire
